FILE: rtl/core/itoa_fmt_pkg.sv
// shared types, format kind codes and character tables for the integer to ascii formatter
// used by itoa_fmt_ctrl, itoa_fmt_dp and the top level; depends on nothing

package itoa_fmt_pkg;

    localparam int          HEX_BITS = 64;
    localparam logic [63:0] HEX_MASK = {64{1'b1}} >> (64 - HEX_BITS);

    localparam int DEC_DIGITS = 10;
    localparam int BCD_W      = 4 * DEC_DIGITS;
    localparam int NIBBLES    = 16;

    // format kinds as carried in tuser
    localparam logic [2:0] KIND_SDEC = 3'd0;
    localparam logic [2:0] KIND_UDEC = 3'd1;
    localparam logic [2:0] KIND_HEXL = 3'd2;
    localparam logic [2:0] KIND_HEXU = 3'd3;
    localparam logic [2:0] KIND_PTR  = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CONV  = 4'b0010,
        ST_COUNT = 4'b0100,
        ST_EMIT  = 4'b1000
    } t_state;

    typedef struct packed {
        logic load;
        logic conv_step;
        logic count;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic kind_ok;
        logic kind_dec;
        logic conv_done;
        logic emit_done;
    } t_dp_sts;

    function automatic logic [7:0] digit_char(input logic [3:0] nib, input logic upper);
        logic [7:0] c;
        begin
            if (nib < 4'd10) begin
                c = 8'h30 + {4'd0, nib};
            end else if (upper) begin
                c = 8'h41 + {4'd0, nib} - 8'd10;
            end else begin
                c = 8'h61 + {4'd0, nib} - 8'd10;
            end
            return c;
        end
    endfunction

    function automatic logic [7:0] prefix_char(input logic [2:0] kind, input logic nil,
                                               input logic [2:0] idx);
        logic [7:0] c;
        begin
            c = 8'h2d;  // '-'
            if (kind == KIND_PTR) begin
                if (nil) begin
                    case (idx)
                        3'd0:    c = 8'h28;  // '('
                        3'd1:    c = 8'h6e;  // 'n'
                        3'd2:    c = 8'h69;  // 'i'
                        3'd3:    c = 8'h6c;  // 'l'
                        default: c = 8'h29;  // ')'
                    endcase
                end else if (idx == 3'd0) begin
                    c = 8'h30;
                end else begin
                    c = 8'h78;  // 'x'
                end
            end
            return c;
        end
    endfunction

endpackage

FILE: rtl/core/itoa_fmt_ctrl.sv
// controller state machine of the integer to ascii formatter
// depends on itoa_fmt_pkg; drives the datapath through t_dp_cmd and reads t_dp_sts

module itoa_fmt_ctrl
    import itoa_fmt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    output logic    o_s_tready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_s_tready = (r_state == ST_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;

    always_comb begin
        o_cmd           = '0;
        o_cmd.load      = accept;
        o_cmd.conv_step = (r_state == ST_CONV);
        o_cmd.count     = (r_state == ST_COUNT);
        o_cmd.emit      = (r_state == ST_EMIT);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                // unused kinds are dropped here
                if (accept && i_sts.kind_ok) begin
                    n_state = i_sts.kind_dec ? ST_CONV : ST_COUNT;
                end
            end
            ST_CONV: begin
                if (i_sts.conv_done) begin
                    n_state = ST_COUNT;
                end
            end
            ST_COUNT: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_sts.emit_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: rtl/core/itoa_fmt_dp.sv
// datapath of the integer to ascii formatter: binary to bcd, digit count, character output
// depends on itoa_fmt_pkg; controlled by itoa_fmt_ctrl

module itoa_fmt_dp
    import itoa_fmt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [63:0] i_value,
    input  logic [2:0]  i_req_type,
    input  t_dp_cmd     i_cmd,
    output t_dp_sts     o_sts,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_out_char,
    output logic        o_last,
    output logic [4:0]  o_total_length
);

    logic [2:0]  r_kind;
    logic [63:0] r_digits;
    logic [31:0] r_bin;
    logic [2:0]  r_step;
    logic        r_neg;
    logic        r_nil;
    logic [2:0]  r_pre;
    logic [4:0]  r_total;
    logic [4:0]  r_idx;

    logic        r_m_valid;
    logic [7:0]  r_m_char;
    logic        r_m_last;
    logic [4:0]  r_m_len;

    logic        in_neg;
    logic [31:0] in_mag;
    logic [BCD_W-1:0] n_bcd;
    logic [31:0] n_bin;
    logic [3:0]  hi_nib;
    logic        any_nz;
    logic [4:0]  ndig;
    logic [2:0]  pre;
    logic        nil;
    logic        fire;
    logic        is_last;
    logic [3:0]  dig_sel;
    logic [3:0]  nib;
    logic [7:0]  chr;

    assign in_neg = (i_req_type == KIND_SDEC) && i_value[31];
    assign in_mag = in_neg ? (32'd0 - i_value[31:0]) : i_value[31:0];

    // four double-dabble bit steps per cycle
    always_comb begin
        logic [BCD_W-1:0] b;
        logic [31:0]      s;
        b = r_digits[BCD_W-1:0];
        s = r_bin;
        for (int k = 0; k < 4; k++) begin
            for (int d = 0; d < DEC_DIGITS; d++) begin
                if (b[4*d +: 4] >= 4'd5) begin
                    b[4*d +: 4] = b[4*d +: 4] + 4'd3;
                end
            end
            b = {b[BCD_W-2:0], s[31]};
            s = {s[30:0], 1'b0};
        end
        n_bcd = b;
        n_bin = s;
    end

    // highest nonzero digit
    always_comb begin
        hi_nib = '0;
        any_nz = 1'b0;
        for (int i = 0; i < NIBBLES; i++) begin
            if (r_digits[4*i +: 4] != 4'd0) begin
                hi_nib = 4'(i);
                any_nz = 1'b1;
            end
        end
        ndig = any_nz ? ({1'b0, hi_nib} + 5'd1) : 5'd1;
        nil  = (r_kind == KIND_PTR) && !any_nz;
        pre  = 3'd0;
        if (r_kind == KIND_SDEC && r_neg) begin
            pre = 3'd1;
        end else if (r_kind == KIND_PTR) begin
            pre = nil ? 3'd5 : 3'd2;
        end
    end

    assign fire    = i_cmd.emit && (!r_m_valid || i_m_tready);
    assign is_last = (r_idx == r_total - 5'd1);
    assign dig_sel = 4'(r_total - 5'd1 - r_idx);
    assign nib     = r_digits[{dig_sel, 2'b00} +: 4];
    assign chr     = ({2'b00, r_pre} > r_idx) ? prefix_char(r_kind, r_nil, r_idx[2:0])
                                              : digit_char(nib, r_kind == KIND_HEXU);

    always_comb begin
        o_sts           = '0;
        o_sts.kind_ok   = (i_req_type <= KIND_PTR);
        o_sts.kind_dec  = (i_req_type == KIND_SDEC) || (i_req_type == KIND_UDEC);
        o_sts.conv_done = i_cmd.conv_step && (r_step == 3'd7);
        o_sts.emit_done = fire && is_last;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_req_type;
            r_neg  <= in_neg;
            r_bin  <= in_mag;
            r_step <= '0;
            if (o_sts.kind_dec) begin
                r_digits <= '0;
            end else begin
                r_digits <= i_value & HEX_MASK;
            end
        end else if (i_cmd.conv_step) begin
            r_digits <= {{(64 - BCD_W){1'b0}}, n_bcd};
            r_bin    <= n_bin;
            r_step   <= r_step + 3'd1;
        end
        if (i_cmd.count) begin
            r_nil   <= nil;
            r_pre   <= pre;
            r_total <= nil ? 5'd5 : ({2'b00, pre} + ndig);
            r_idx   <= '0;
        end else if (fire) begin
            r_idx <= r_idx + 5'd1;
        end
        if (fire) begin
            r_m_char <= chr;
            r_m_last <= is_last;
            r_m_len  <= r_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (fire) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    assign o_m_tvalid     = r_m_valid;
    assign o_out_char     = r_m_char;
    assign o_last         = r_m_last;
    assign o_total_length = r_m_len;

endmodule

FILE: rtl/core/integer_to_ascii_formatter.sv
// top level of the integer to ascii formatter
// depends on itoa_fmt_pkg, itoa_fmt_ctrl and itoa_fmt_dp

// Converts one 64-bit value per input beat into ASCII text, one output beat per
// character, most significant first, tlast on the final character. tuser selects the
// format: 0 signed 32-bit decimal, 1 unsigned 32-bit decimal, 2 hex lower case,
// 3 hex upper case, 4 pointer ("0x" and lower-case hex, "(nil)" for zero); codes 5 to 7
// give no output. Every output beat carries the total character count. One value is
// worked on at a time: after the input beat, decimal kinds pass through the binary to
// bcd unit (4 bits per cycle) and all kinds then pass through the digit count state;
// characters then leave at one per cycle while the sink does not stall. The next
// input beat is taken while the last character still waits in the output register.

module integer_to_ascii_formatter
    import itoa_fmt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // [63:0] value
    input  logic [2:0]  i_s_tuser,   // [2:0] req_type
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [7:0] out_char, [12:8] total_length, [15:13] zero
    output logic        o_m_tlast
);

    t_dp_cmd    cmd;
    t_dp_sts    sts;
    logic [7:0] out_char;
    logic [4:0] total_length;

    itoa_fmt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    itoa_fmt_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_value        (i_s_tdata),
        .i_req_type     (i_s_tuser),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_m_tvalid     (o_m_tvalid),
        .i_m_tready     (i_m_tready),
        .o_out_char     (out_char),
        .o_last         (o_m_tlast),
        .o_total_length (total_length)
    );

    assign o_m_tdata = {3'b000, total_length, out_char};

endmodule
